[sv/pidpi_pkg.sv]
// Shared constants for the positional/incremental PID unit.
`default_nettype none
package pidpi_pkg;

  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd5;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic MODE_POS = 1'b0;
  localparam logic MODE_INC = 1'b1;

  // integral limit factor 0.8 as 819/1024
  localparam int ILIM_MUL   = 819;
  localparam int ILIM_MUL_W = 10;
  localparam int ILIM_SHIFT = 10;

endpackage
`default_nettype wire

[sv/pidpi_cfg.sv]
// Configuration register file of the PID unit.
`default_nettype none
module pidpi_cfg #(
  parameter int DATA_WIDTH = 16,
  localparam int CfgW = (DATA_WIDTH > pidpi_pkg::GAIN_W) ? DATA_WIDTH : pidpi_pkg::GAIN_W
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [pidpi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CfgW-1:0]                       cfg_data,
  output logic                                       mode,
  output logic signed [DATA_WIDTH-1:0]               setpoint,
  output logic signed [pidpi_pkg::GAIN_W-1:0]        gain_p,
  output logic signed [pidpi_pkg::GAIN_W-1:0]        gain_i,
  output logic signed [pidpi_pkg::GAIN_W-1:0]        gain_d,
  output logic [DATA_WIDTH-2:0]                      drive_limit
);
  import pidpi_pkg::*;

  logic                         mode_r;
  logic signed [DATA_WIDTH-1:0] setpoint_r;
  logic signed [GAIN_W-1:0]     gain_p_r;
  logic signed [GAIN_W-1:0]     gain_i_r;
  logic signed [GAIN_W-1:0]     gain_d_r;
  logic [DATA_WIDTH-2:0]        limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_POS;
      setpoint_r <= '0;
      gain_p_r   <= '0;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
      limit_r    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     mode_r     <= cfg_data[0];
        REG_SETPOINT: setpoint_r <= $signed(cfg_data[DATA_WIDTH-1:0]);
        REG_GAIN_P:   gain_p_r   <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_I:   gain_i_r   <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_D:   gain_d_r   <= $signed(cfg_data[GAIN_W-1:0]);
        REG_LIMIT:    limit_r    <= cfg_data[DATA_WIDTH-2:0];
        default: begin
        end
      endcase
    end
  end

  assign mode        = mode_r;
  assign setpoint    = setpoint_r;
  assign gain_p      = gain_p_r;
  assign gain_i      = gain_i_r;
  assign gain_d      = gain_d_r;
  assign drive_limit = limit_r;

endmodule
`default_nettype wire

[sv/pidpi_core.sv]
// PID datapath: error, integral clamp, three gain products, output clamp and history.
`default_nettype none
module pidpi_core #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  step_en,
  input  wire logic                                  cmd,
  input  wire logic signed [DATA_WIDTH-1:0]          measurement,
  input  wire logic                                  mode,
  input  wire logic signed [DATA_WIDTH-1:0]          setpoint,
  input  wire logic signed [pidpi_pkg::GAIN_W-1:0]   gain_p,
  input  wire logic signed [pidpi_pkg::GAIN_W-1:0]   gain_i,
  input  wire logic signed [pidpi_pkg::GAIN_W-1:0]   gain_d,
  input  wire logic [DATA_WIDTH-2:0]                 drive_limit,
  output logic signed [DATA_WIDTH-1:0]               drive,
  output logic                                       clamped
);
  import pidpi_pkg::*;

  localparam int ErrW  = DATA_WIDTH + 1;
  localparam int OpW   = DATA_WIDTH + 3;
  localparam int ProdW = GAIN_W + OpW;
  localparam int AccW  = DATA_WIDTH + 22;
  localparam int LimW  = DATA_WIDTH - 1;
  localparam int IlpW  = LimW + ILIM_MUL_W;

  logic signed [DATA_WIDTH-1:0] integral_r, integral_nxt;
  logic signed [DATA_WIDTH-1:0] held_r, held_nxt;
  logic signed [ErrW-1:0]       prev_r, prev_nxt;
  logic signed [ErrW-1:0]       prev2_r, prev2_nxt;
  logic signed [ErrW-1:0]       err;
  logic [IlpW-1:0]              ilim_prod;
  logic [LimW-1:0]              ilim;
  logic signed [AccW-1:0]       ilim_s, lim_s, isum_pre, isum_cl;
  logic signed [OpW-1:0]        diff1, diff2, p_op, i_op, d_op;
  logic signed [ProdW-1:0]      p_prod, i_prod, d_prod;
  logic signed [AccW-1:0]       acc, acc_sh, raw, drive_cl;
  logic                         hit;

  assign err       = ErrW'(setpoint) - ErrW'(measurement);
  assign ilim_prod = IlpW'(drive_limit) * IlpW'(ILIM_MUL);
  assign ilim      = ilim_prod[IlpW-1:ILIM_SHIFT];
  assign ilim_s    = $signed(AccW'(ilim));
  assign lim_s     = $signed(AccW'(drive_limit));
  assign isum_pre  = AccW'(integral_r) + AccW'(err);

  always_comb begin
    priority if (isum_pre > ilim_s) begin
      isum_cl = ilim_s;
    end else if (isum_pre < -ilim_s) begin
      isum_cl = -ilim_s;
    end else begin
      isum_cl = isum_pre;
    end
  end

  assign diff1 = OpW'(err) - OpW'(prev_r);
  assign diff2 = OpW'(err) - (OpW'(prev_r) <<< 1) + OpW'(prev2_r);

  always_comb begin
    unique case (mode)
      MODE_INC: begin
        p_op = diff1;
        i_op = OpW'(err);
        d_op = diff2;
      end
      default: begin
        p_op = OpW'(err);
        i_op = OpW'(isum_cl);
        d_op = diff1;
      end
    endcase
  end

  assign p_prod = gain_p * p_op;
  assign i_prod = gain_i * i_op;
  assign d_prod = gain_d * d_op;
  assign acc    = AccW'(p_prod) + AccW'(i_prod) + AccW'(d_prod);
  assign acc_sh = acc >>> GAIN_FRAC_BITS;
  assign raw    = (mode == MODE_INC) ? AccW'(held_r) + acc_sh : acc_sh;

  always_comb begin
    priority if (raw > lim_s) begin
      drive_cl = lim_s;
      hit      = 1'b1;
    end else if (raw < -lim_s) begin
      drive_cl = -lim_s;
      hit      = 1'b1;
    end else begin
      drive_cl = raw;
      hit      = 1'b0;
    end
  end

  assign drive   = (cmd == CMD_CLEAR) ? '0 : drive_cl[DATA_WIDTH-1:0];
  assign clamped = (cmd == CMD_STEP) && hit;

  always_comb begin
    integral_nxt = integral_r;
    prev_nxt     = err;
    prev2_nxt    = prev2_r;
    held_nxt     = drive_cl[DATA_WIDTH-1:0];
    if (cmd == CMD_CLEAR) begin
      integral_nxt = '0;
      prev_nxt     = '0;
      prev2_nxt    = '0;
      held_nxt     = '0;
    end else if (mode == MODE_INC) begin
      prev2_nxt = prev_r;
    end else begin
      integral_nxt = isum_cl[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_r     <= '0;
      prev2_r    <= '0;
      held_r     <= '0;
    end else if (step_en) begin
      integral_r <= integral_nxt;
      prev_r     <= prev_nxt;
      prev2_r    <= prev2_nxt;
      held_r     <= held_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_zeroes_history: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && cmd == CMD_CLEAR |=>
      integral_r == '0 && prev_r == '0 && prev2_r == '0 && held_r == '0)
    else $error("history not cleared");

  a_pos_keeps_prev2: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && cmd == CMD_STEP && mode == MODE_POS |=> $stable(prev2_r))
    else $error("positional step changed second history");

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && clamped |-> drive_cl == lim_s || drive_cl == -lim_s)
    else $error("clamped word not at limit");
`endif

endmodule
`default_nettype wire

[sv/pid_positional_incremental_unit.sv]
// Top level of the PID unit: input stage, datapath, result register and config port.
`default_nettype none
// Fixed-point PID controller, positional or incremental by the mode register. Each input
// word is either a control step on a signed measurement or a clear of all history, and
// yields exactly one result word (clamped drive and a clamp flag). An accepted word goes
// into one input register, then through the whole step (error, integral clamp, three
// parallel gain multiplies, floor shift, output clamp) in one pass into the result
// register, which it enters once the result register is empty or being drained. The
// history registers update in that same pass, so a new word is taken every cycle while
// the result side keeps up. Write configuration only while idle.
module pid_positional_incremental_unit #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8,
  localparam int CfgW = (DATA_WIDTH > pidpi_pkg::GAIN_W) ? DATA_WIDTH : pidpi_pkg::GAIN_W
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_cmd,
  input  wire logic signed [DATA_WIDTH-1:0]      in_measurement,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [DATA_WIDTH-1:0]           out_drive,
  output logic                                   out_clamped,
  input  wire logic                              cfg_we,
  input  wire logic [pidpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CfgW-1:0]                   cfg_data
);
  import pidpi_pkg::*;

  logic                         s1_valid_r;
  logic                         cmd_r;
  logic signed [DATA_WIDTH-1:0] meas_r;
  logic                         s1_adv;
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] drive_r;
  logic                         clamped_r;

  logic                         mode;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [GAIN_W-1:0]     gain_p, gain_i, gain_d;
  logic [DATA_WIDTH-2:0]        drive_limit;
  logic signed [DATA_WIDTH-1:0] core_drive;
  logic                         core_clamped;

  pidpi_cfg #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .setpoint    (setpoint),
    .gain_p      (gain_p),
    .gain_i      (gain_i),
    .gain_d      (gain_d),
    .drive_limit (drive_limit)
  );

  pidpi_core #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_adv),
    .cmd         (cmd_r),
    .measurement (meas_r),
    .mode        (mode),
    .setpoint    (setpoint),
    .gain_p      (gain_p),
    .gain_i      (gain_i),
    .gain_d      (gain_d),
    .drive_limit (drive_limit),
    .drive       (core_drive),
    .clamped     (core_clamped)
  );

  // advance when the result register is empty or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      meas_r <= in_measurement;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      drive_r   <= core_drive;
      clamped_r <= core_clamped;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = drive_r;
  assign out_clamped = clamped_r;

`ifndef SYNTHESIS
  a_clear_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && cmd_r == CMD_CLEAR |=> out_valid_r && drive_r == '0 && !clamped_r)
    else $error("clear word did not give zero result");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced word lost");

  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without backpressure");
`endif

endmodule
`default_nettype wire
